/* rtl/ipcsf_pkg.sv */
// Shared types and constants for the interprocessor mailbox.
// No dependencies; imported by every module of the block but the checker.
`default_nettype none

package ipcsf_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned STAT_W    = 16;
	localparam int unsigned STALL_W   = 20;
	localparam int unsigned RSP_W     = 21;
	localparam int unsigned SYNC_RD_W = 15;

	localparam logic [3:0]       COUNT_START = 4'd8;
	localparam logic [RSP_W-1:0] STALL_MAX   = {RSP_W{1'b1}};

	typedef enum logic [2:0] {
		ACT_SYNC_RD  = 3'd0,
		ACT_SYNC_WR  = 3'd1,
		ACT_CTRL_RD  = 3'd2,
		ACT_CTRL_WR  = 3'd3,
		ACT_SEND     = 3'd4,
		ACT_RECV     = 3'd5,
		ACT_PART_PSH = 3'd6,
		ACT_PART_POP = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		CFG_MODEL_ON    = 2'd0,
		CFG_AUTO_DRAIN  = 2'd1,
		CFG_STALL_LIMIT = 2'd2
	} cfg_idx_t;

	// queue update for one transfer; push and pop may coincide (auto drain)
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} q_ctrl_t;

	typedef struct packed {
		logic rd;	// sync read, counted even with the model off
		logic wr;	// sync write, model on
	} sync_ctrl_t;

endpackage

`default_nettype wire

/* rtl/ipcsf_queue.sv */
// Word ring buffer with a prefetched head word.
// Depends on ipcsf_pkg.
`default_nettype none

module ipcsf_queue #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  ipcsf_pkg::q_ctrl_t          ctrl,
	input  wire [ipcsf_pkg::WORD_W-1:0] push_data,
	output logic [CW-1:0]               count,
	output logic [CW-1:0]               count_nx,
	output logic [ipcsf_pkg::WORD_W-1:0] pop_word
);
	import ipcsf_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] head_word_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     head_nx;
	logic [AW-1:0]     waddr;
	logic [CW:0]       tail_sum;

	// tail = (head + count) mod DEPTH, sum below twice the depth
	always_comb begin
		tail_sum = (CW + 1)'(head_q) + (CW + 1)'(count_q);
		if (tail_sum >= (CW + 1)'(DEPTH))
			tail_sum = tail_sum - (CW + 1)'(DEPTH);
		waddr = tail_sum[AW-1:0];
	end

	always_comb begin
		if (ctrl.clear)
			head_nx = '0;
		else if (ctrl.pop)
			head_nx = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
		else
			head_nx = head_q;
		if (ctrl.clear)
			count_nx = '0;
		else
			count_nx = count_q + CW'(ctrl.push) - CW'(ctrl.pop);
	end

	// pop of a queue that is empty before the push hands the pushed word through
	assign pop_word = (count_q == '0) ? push_data : head_word_q;
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (ctrl.push)
			mem[waddr] <= push_data;
		if (ctrl.push && (waddr == head_nx))
			head_word_q <= push_data;
		else
			head_word_q <= mem[head_nx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_nx;
			count_q <= count_nx;
		end
	end

endmodule

`default_nettype wire

/* rtl/ipcsf_sync.sv */
// Sync register, partner countdown handshake and stall counter.
// Depends on ipcsf_pkg.
`default_nettype none

module ipcsf_sync (
	input  wire                            clk,
	input  wire                            arst_n,
	input  ipcsf_pkg::sync_ctrl_t          ctrl,
	input  wire [3:0]                      wr_nibble,
	input  wire [1:0]                      wr_irq,
	input  wire [ipcsf_pkg::STALL_W-1:0]   stall_limit,
	output logic [ipcsf_pkg::SYNC_RD_W-1:0] sync_word,
	output logic                           stall_trip_nx,
	output logic                           complete_nx
);
	import ipcsf_pkg::*;

	logic [3:0]       own_q, own_nx;
	logic [1:0]       irq_q, irq_nx;
	logic [3:0]       pnib_q, pnib_nx;
	logic [3:0]       cd_q, cd_nx, cd_eff;
	logic             complete_q;
	logic [RSP_W-1:0] rsp_q, rsp_nx;

	assign sync_word = {irq_q, 1'b0, own_q, 4'b0000, pnib_q};

	always_comb begin
		own_nx      = own_q;
		irq_nx      = irq_q;
		pnib_nx     = pnib_q;
		cd_nx       = cd_q;
		complete_nx = complete_q;
		rsp_nx      = rsp_q;
		cd_eff      = (wr_nibble != cd_q) ? COUNT_START : cd_q;
		if (ctrl.wr) begin
			own_nx = wr_nibble;
			irq_nx = wr_irq;
			rsp_nx = '0;
			if (!complete_q) begin
				// countdown already at zero: stepping below it ends the handshake
				if (cd_eff == 4'd0)
					complete_nx = 1'b1;
				else begin
					cd_nx   = cd_eff - 4'd1;
					pnib_nx = cd_eff - 4'd1;
				end
			end
		end else if (ctrl.rd && (rsp_q != STALL_MAX))
			rsp_nx = rsp_q + RSP_W'(1);
		stall_trip_nx = rsp_nx > RSP_W'(stall_limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q      <= '0;
			irq_q      <= '0;
			pnib_q     <= COUNT_START;
			cd_q       <= COUNT_START;
			complete_q <= 1'b0;
			rsp_q      <= '0;
		end else begin
			own_q      <= own_nx;
			irq_q      <= irq_nx;
			pnib_q     <= pnib_nx;
			cd_q       <= cd_nx;
			complete_q <= complete_nx;
			rsp_q      <= rsp_nx;
		end
	end

endmodule

`default_nettype wire

/* rtl/interprocessor_sync_fifo_top.sv */
// Interprocessor mailbox, local processor view: top level.
// Depends on ipcsf_pkg, ipcsf_queue and ipcsf_sync.
`default_nettype none

// One transfer is taken on every cycle that start is high; busy never rises.
// Each transfer gives exactly one result, marked by done: the input register is
// loaded first, then the new mailbox state is committed and the result register
// loaded together. Throughput is one transfer per cycle, bounded by the
// single pass of queue, sync and status logic. The
// receiver cannot stall, so results must be taken on the done cycle; the
// result ports hold their last value between transfers. Each queue keeps its
// head word in a register read ahead from the queue memory, so a pop never
// waits on a memory read. Configuration writes take effect at once and are
// expected only while no transfer is in flight. There is no clearing pass.
module interprocessor_sync_fifo_top #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [2:0]  action,
	input  wire  [31:0] data,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [19:0] cfg_wdata,
	output logic        done,
	output logic [31:0] read_data,
	output logic [15:0] status_word,
	output logic        access_handled,
	output logic        rx_irq,
	output logic [31:0] partner_word,
	output logic        partner_word_valid,
	output logic        stall_trip,
	output logic        handshake_done
);
	import ipcsf_pkg::*;

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	// configuration
	logic               model_on_q;
	logic               auto_drain_q;
	logic [STALL_W-1:0] stall_limit_q;

	// input register
	logic              valid_s1;
	logic [2:0]        action_s1;
	logic [WORD_W-1:0] data_s1;

	// mailbox state held here
	logic [2:0]        en_q, en_nx;	// bit0 send-empty irq, bit1 recv irq, bit2 enable
	logic              err_q, err_nx;
	logic [WORD_W-1:0] last_q, last_nx;

	// result register
	logic              done_q;
	logic [WORD_W-1:0] rd_q;
	logic [STAT_W-1:0] stat_q;
	logic              handled_q, rx_irq_q, pw_valid_q, trip_q, hs_done_q;
	logic [WORD_W-1:0] pw_q;

	action_t           act;
	logic              on;
	q_ctrl_t           sq_ctrl, rq_ctrl;
	sync_ctrl_t        sy_ctrl;
	logic [CW-1:0]     send_cnt, send_cnt_nx, recv_cnt, recv_cnt_nx;
	logic [WORD_W-1:0] send_word, recv_word;
	logic              send_full, recv_full, rq_empty;
	logic [SYNC_RD_W-1:0] sync_word;
	logic              trip_nx, complete_nx;
	logic [WORD_W-1:0] rd_nx, pw_nx;
	logic              handled_nx;
	logic [STAT_W-1:0] stat_now, stat_nx;

	function automatic logic [STAT_W-1:0] status_pack(
		input logic [2:0] en,
		input logic       s_empty,
		input logic       s_full,
		input logic       r_empty,
		input logic       r_full,
		input logic       err
	);
		logic [STAT_W-1:0] v;
		v     = '0;
		v[0]  = s_empty;
		v[1]  = s_full;
		v[2]  = en[0];
		v[8]  = r_empty;
		v[9]  = r_full;
		v[10] = en[1];
		v[14] = err;
		v[15] = en[2];
		return v;
	endfunction

	assign busy = 1'b0;

	assign act        = action_t'(action_s1);
	assign on         = model_on_q;
	assign send_full  = send_cnt == CW'(QUEUE_DEPTH);
	assign recv_full  = recv_cnt == CW'(QUEUE_DEPTH);
	assign rq_empty   = recv_cnt == '0;

	// queue and sync controls for the transfer in the input register
	always_comb begin
		sq_ctrl.push  = valid_s1 && on && (act == ACT_SEND) && en_q[2] && !send_full;
		sq_ctrl.pop   = (sq_ctrl.push && auto_drain_q) ||
		                (valid_s1 && on && (act == ACT_PART_POP) && (send_cnt != '0));
		sq_ctrl.clear = valid_s1 && on && (act == ACT_CTRL_WR) && data_s1[3];
		rq_ctrl.push  = valid_s1 && on && (act == ACT_PART_PSH) && !recv_full;
		rq_ctrl.pop   = valid_s1 && on && (act == ACT_RECV) && !rq_empty;
		rq_ctrl.clear = 1'b0;
		sy_ctrl.rd    = valid_s1 && (act == ACT_SYNC_RD);
		sy_ctrl.wr    = valid_s1 && on && (act == ACT_SYNC_WR);
	end

	ipcsf_queue #(.DEPTH(QUEUE_DEPTH), .CW(CW)) u_send_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (sq_ctrl),
		.push_data (data_s1),
		.count     (send_cnt),
		.count_nx  (send_cnt_nx),
		.pop_word  (send_word)
	);

	ipcsf_queue #(.DEPTH(QUEUE_DEPTH), .CW(CW)) u_recv_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (rq_ctrl),
		.push_data (data_s1),
		.count     (recv_cnt),
		.count_nx  (recv_cnt_nx),
		.pop_word  (recv_word)
	);

	ipcsf_sync u_sync (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (sy_ctrl),
		.wr_nibble     (data_s1[11:8]),
		.wr_irq        (data_s1[14:13]),
		.stall_limit   (stall_limit_q),
		.sync_word     (sync_word),
		.stall_trip_nx (trip_nx),
		.complete_nx   (complete_nx)
	);

	// enables, sticky error and last received word
	always_comb begin
		en_nx   = en_q;
		err_nx  = err_q;
		last_nx = rq_ctrl.pop ? recv_word : last_q;
		if (valid_s1 && on) begin
			case (act)
				ACT_CTRL_WR: begin
					en_nx = {data_s1[15], data_s1[10], data_s1[2]};
					if (data_s1[14])
						err_nx = 1'b0;
				end
				ACT_SEND: if (en_q[2] && send_full) err_nx = 1'b1;
				ACT_RECV: if (rq_empty) err_nx = 1'b1;
				ACT_PART_PSH: if (recv_full) err_nx = 1'b1;
				default: ;
			endcase
		end
	end

	// read path; status before and after the transfer
	always_comb begin
		stat_now = status_pack(en_q, send_cnt == '0, send_full, rq_empty, recv_full,
		                       err_q);
		stat_nx  = on ? status_pack(en_nx, send_cnt_nx == '0,
		                            send_cnt_nx == CW'(QUEUE_DEPTH), recv_cnt_nx == '0,
		                            recv_cnt_nx == CW'(QUEUE_DEPTH), err_nx) : '0;
		rd_nx      = '0;
		handled_nx = 1'b0;
		case (act)
			ACT_SYNC_RD: begin
				handled_nx = on;
				rd_nx      = on ? WORD_W'(sync_word) : '0;
			end
			ACT_CTRL_RD: begin
				handled_nx = on;
				rd_nx      = on ? WORD_W'(stat_now) : '0;
			end
			ACT_RECV: begin
				// still answered with the model off, then as zero
				handled_nx = 1'b1;
				if (on)
					rd_nx = rq_empty ? last_q : recv_word;
			end
			default: ;
		endcase
		pw_nx = sq_ctrl.pop ? send_word : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_on_q    <= 1'b1;
			auto_drain_q  <= 1'b1;
			stall_limit_q <= STALL_W'(100000);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MODEL_ON:    model_on_q    <= cfg_wdata[0];
				CFG_AUTO_DRAIN:  auto_drain_q  <= cfg_wdata[0];
				CFG_STALL_LIMIT: stall_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			en_q     <= '0;
			err_q    <= 1'b0;
			last_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start;
			en_q     <= en_nx;
			err_q    <= err_nx;
			last_q   <= last_nx;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			action_s1 <= action;
			data_s1   <= data;
		end
	end

	// result register: holds until the next transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q       <= '0;
			stat_q     <= '0;
			handled_q  <= 1'b0;
			rx_irq_q   <= 1'b0;
			pw_q       <= '0;
			pw_valid_q <= 1'b0;
			trip_q     <= 1'b0;
			hs_done_q  <= 1'b0;
		end else if (valid_s1) begin
			rd_q       <= rd_nx;
			stat_q     <= stat_nx;
			handled_q  <= handled_nx;
			rx_irq_q   <= on && en_nx[2] && en_nx[1] && (recv_cnt_nx != '0);
			pw_q       <= pw_nx;
			pw_valid_q <= sq_ctrl.pop;
			trip_q     <= trip_nx;
			hs_done_q  <= complete_nx;
		end
	end

	assign done               = done_q;
	assign read_data          = rd_q;
	assign status_word        = stat_q;
	assign access_handled     = handled_q;
	assign rx_irq             = rx_irq_q;
	assign partner_word       = pw_q;
	assign partner_word_valid = pw_valid_q;
	assign stall_trip         = trip_q;
	assign handshake_done     = hs_done_q;

endmodule

`default_nettype wire

/* rtl/ipcsf_checker.sv */
// Port-level checks for the interprocessor mailbox top level.
// No dependencies; bound to interprocessor_sync_fifo_top below.
`default_nettype none

module ipcsf_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire        done,
	input wire [31:0] partner_word,
	input wire        partner_word_valid,
	input wire [15:0] status_word,
	input wire        rx_irq,
	input wire        handshake_done
);

	// every accepted transfer gives its result, strobed by done
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result missing two cycles after transfer");

	// no result without an accepted transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##2 !done)
		else $error("result without transfer");

	// handshake completion never falls back
	a_hs_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		handshake_done |=> handshake_done)
		else $error("handshake_done fell");

	// irq needs enable, recv irq enable and a non-empty receive queue
	a_irq_status: assert property (@(posedge clk) disable iff (!arst_n)
		rx_irq |-> (status_word[15] && status_word[10] && !status_word[8]))
		else $error("rx_irq disagrees with status");

	a_pw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!partner_word_valid |-> (partner_word == 32'd0))
		else $error("partner_word set without valid");

endmodule

bind interprocessor_sync_fifo_top ipcsf_checker u_ipcsf_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for interprocessor_sync_fifo_top: a directed pass, then random traffic.
// Predicts every transfer with a behavioural model and checks each result as it is strobed.
// Depends on ipcsf_pkg and the block's RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ipcsf_pkg::*;

	localparam int QDEPTH = 16;

	// expected result of one transfer
	typedef struct packed {
		logic [31:0] read_data;
		logic [15:0] status;
		logic        handled;
		logic        rx_irq;
		logic [31:0] pword;
		logic        pvalid;
		logic        stall;
		logic        hs;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  action = '0;
	logic [31:0] data = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [19:0] cfg_wdata = '0;
	wire         busy;
	wire         done;
	wire  [31:0] read_data;
	wire  [15:0] status_word;
	wire         access_handled;
	wire         rx_irq;
	wire  [31:0] partner_word;
	wire         partner_word_valid;
	wire         stall_trip;
	wire         handshake_done;

	interprocessor_sync_fifo_top #(.QUEUE_DEPTH(QDEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .data(data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.done(done), .read_data(read_data), .status_word(status_word),
		.access_handled(access_handled), .rx_irq(rx_irq),
		.partner_word(partner_word), .partner_word_valid(partner_word_valid),
		.stall_trip(stall_trip), .handshake_done(handshake_done)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Mailbox model: register copy and state, all at reset values
	// ---------------------------------------------------------------
	bit          model_en = 1'b1;
	bit          drain_en = 1'b1;
	logic [19:0] stall_lim = 20'd100000;

	logic [31:0] send_q[$];		// local to partner
	logic [31:0] recv_q[$];		// partner to local
	logic [31:0] last_rx = '0;
	bit          err = 1'b0;
	logic [2:0]  ctrl_en = '0;	// {enable, recv irq, send-empty irq}
	logic [3:0]  own_nib = '0;
	logic [3:0]  peer_nib = COUNT_START;
	logic [1:0]  sync_irq = '0;
	int          countdown = 8;
	bit          hs_done = 1'b0;
	logic [20:0] stall_cnt = '0;

	result_t     due_results[$];	// one entry per transfer in flight
	int          mismatches = 0;
	bit          steady = 1'b0;	// no idling between transfers
	int unsigned mix[8] = '{1, 1, 1, 1, 1, 1, 1, 1};	// action weights

	function automatic logic [15:0] status_bits();
		logic [15:0] s;
		s = '0;
		s[0]  = (send_q.size() == 0);
		s[1]  = (send_q.size() >= QDEPTH);
		s[2]  = ctrl_en[0];
		s[8]  = (recv_q.size() == 0);
		s[9]  = (recv_q.size() >= QDEPTH);
		s[10] = ctrl_en[1];
		s[14] = err;
		s[15] = ctrl_en[2];
		return s;
	endfunction

	// advance the mailbox by one transfer and return what the block should report
	function automatic result_t mailbox_step(action_t act, logic [31:0] d);
		result_t r;
		r = '0;
		if (!model_en) begin
			// only the stall counter runs; receive reads are still answered with zero
			if (act == ACT_SYNC_RD && stall_cnt != STALL_MAX) stall_cnt++;
			if (act == ACT_RECV) r.handled = 1'b1;
		end else begin
			case (act)
				ACT_SYNC_RD: begin
					if (stall_cnt != STALL_MAX) stall_cnt++;
					r.handled = 1'b1;
					r.read_data = {17'b0, sync_irq, 1'b0, own_nib, 4'b0, peer_nib};
				end
				ACT_SYNC_WR: begin
					own_nib = d[11:8];
					sync_irq = d[14:13];
					stall_cnt = '0;
					// partner echoes the countdown; a wrong nibble restarts it
					if (!hs_done) begin
						if (int'(own_nib) != countdown) countdown = 8;
						countdown--;
						if (countdown < 0) hs_done = 1'b1;
						else peer_nib = countdown[3:0];
					end
				end
				ACT_CTRL_RD: begin
					r.handled = 1'b1;
					r.read_data = {16'b0, status_bits()};
				end
				ACT_CTRL_WR: begin
					ctrl_en = {d[15], d[10], d[2]};
					if (d[3]) send_q.delete();
					if (d[14]) err = 1'b0;
				end
				ACT_SEND: begin
					if (ctrl_en[2]) begin
						if (send_q.size() >= QDEPTH) begin
							err = 1'b1;
						end else begin
							send_q.push_back(d);
							if (drain_en) begin
								r.pword = send_q.pop_front();
								r.pvalid = 1'b1;
							end
						end
					end
				end
				ACT_RECV: begin
					r.handled = 1'b1;
					if (recv_q.size() == 0) begin
						err = 1'b1;
						r.read_data = last_rx;
					end else begin
						r.read_data = recv_q.pop_front();
						last_rx = r.read_data;
					end
				end
				ACT_PART_PSH: begin
					if (recv_q.size() >= QDEPTH) err = 1'b1;
					else recv_q.push_back(d);
				end
				default: begin
					if (send_q.size() != 0) begin
						r.pword = send_q.pop_front();
						r.pvalid = 1'b1;
					end
				end
			endcase
		end
		r.status = model_en ? status_bits() : 16'h0;
		r.rx_irq = model_en && ctrl_en[2] && ctrl_en[1] && recv_q.size() > 0;
		r.stall = (stall_cnt > stall_lim);
		r.hs = hs_done;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Result checking: every strobed result against the oldest prediction
	// ---------------------------------------------------------------
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t ns: result strobed with no transfer outstanding", $time);
			end else begin
				want = due_results.pop_front();
				check_field("read_data", want.read_data, read_data);
				check_field("status_word", 32'(want.status), 32'(status_word));
				check_field("access_handled", 32'(want.handled), 32'(access_handled));
				check_field("rx_irq", 32'(want.rx_irq), 32'(rx_irq));
				check_field("partner_word", want.pword, partner_word);
				check_field("partner_word_valid", 32'(want.pvalid), 32'(partner_word_valid));
				check_field("stall_trip", 32'(want.stall), 32'(stall_trip));
				check_field("handshake_done", 32'(want.hs), 32'(handshake_done));
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic int gap_len();
		int unsigned r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one transfer: hold start until accepted, predict, then maybe idle
	// start is only lowered in the gap, so back-to-back transfers keep it high
	task automatic send_item(action_t act, logic [31:0] d);
		int n;
		start <= 1'b1;
		action <= act;
		data <= d;
		do @(posedge clk); while (busy !== 1'b0);
		due_results.push_back(mailbox_step(act, d));
		n = gap_len();
		if (n > 0) begin
			start <= 1'b0;
			action <= 3'($urandom);
			data <= $urandom;
			repeat (n) @(posedge clk);
		end
	endtask

	// stop issuing and wait until every outstanding result has come back
	task automatic settle();
		start <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// only called once settled
	task automatic write_reg(cfg_idx_t idx, logic [19:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= 20'($urandom);
		@(posedge clk);
		case (idx)
			CFG_MODEL_ON:   model_en = v[0];
			CFG_AUTO_DRAIN: drain_en = v[0];
			default:        stall_lim = v;
		endcase
	endtask

	// single-bit register value with junk in the unused upper bits
	function automatic logic [19:0] flag_word(bit b);
		logic [19:0] v;
		v = 20'($urandom);
		v[0] = b;
		return v;
	endfunction

	function automatic action_t pick_action();
		int unsigned total, r;
		total = 0;
		foreach (mix[i]) total += mix[i];
		r = $urandom_range(0, total - 1);
		foreach (mix[i]) begin
			if (r < mix[i]) return action_t'(i);
			r -= mix[i];
		end
		return ACT_SYNC_RD;
	endfunction

	function automatic logic [31:0] pick_data(action_t act);
		logic [31:0] d;
		d = $urandom;
		case (act)
			ACT_SYNC_WR: begin
				if ($urandom_range(0, 2) == 0) d[11:8] = peer_nib;	// echo the countdown
			end
			ACT_CTRL_WR: begin
				d[15] = ($urandom_range(0, 9) != 0);
				d[3] = ($urandom_range(0, 9) == 0);
			end
			default: begin
				case ($urandom_range(0, 19))
					0: d = '0;
					1: d = '1;
					default: ;
				endcase
			end
		endcase
		return d;
	endfunction

	task automatic random_item();
		action_t a;
		a = pick_action();
		send_item(a, pick_data(a));
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// field extremes, every action and the corner cases, from reset
	task automatic test_directed();
		send_item(ACT_SYNC_RD, 32'hFFFF_FFFF);
		send_item(ACT_CTRL_RD, 32'h0);
		send_item(ACT_RECV, 32'h0);		// empty receive queue: error, last word
		send_item(ACT_SEND, 32'hFFFF_FFFF);	// disabled: dropped silently
		send_item(ACT_PART_POP, 32'h0);		// nothing to deliver
		send_item(ACT_CTRL_WR, 32'hFFFF_FFFF);	// all enables, clear queue and error
		send_item(ACT_CTRL_RD, 32'h0);
		send_item(ACT_SEND, 32'hFFFF_FFFF);	// auto drain hands it straight over
		send_item(ACT_SEND, 32'h0);
		send_item(ACT_PART_PSH, 32'hFFFF_FFFF);
		send_item(ACT_PART_PSH, 32'hA5C3_0F96);
		send_item(ACT_RECV, 32'h0);
		send_item(ACT_RECV, 32'h0);
		send_item(ACT_RECV, 32'h0);		// empty again: returns the last word
		send_item(ACT_SYNC_WR, 32'hFFFF_FFFF);	// wrong echo restarts the countdown
		send_item(ACT_SYNC_WR, 32'h0000_0700);	// correct echo of 7
		send_item(ACT_SYNC_RD, 32'h0);
		send_item(ACT_CTRL_WR, 32'h0000_4000);	// acknowledge error, disable
		send_item(ACT_SEND, 32'h0000_0001);
		settle();
		write_reg(CFG_AUTO_DRAIN, flag_word(1'b0));
		send_item(ACT_CTRL_WR, 32'h0000_8400);
		send_item(ACT_SEND, 32'h1111_1111);
		send_item(ACT_SEND, 32'h2222_2222);
		send_item(ACT_PART_POP, 32'h0);
		send_item(ACT_PART_PSH, 32'h0000_0003);	// receive interrupt rises
		send_item(ACT_CTRL_WR, 32'h0000_8408);	// flush the send queue
		send_item(ACT_PART_POP, 32'h0);
		send_item(ACT_RECV, 32'h0);
	endtask

	// balanced traffic with auto drain and the largest stall limit
	task automatic test_mixed_traffic();
		settle();
		write_reg(CFG_AUTO_DRAIN, flag_word(1'b1));
		write_reg(CFG_STALL_LIMIT, 20'hFFFFF);
		mix = '{2, 2, 2, 3, 3, 3, 3, 3};
		steady = 1'b1;
		repeat (100) random_item();
		steady = 1'b0;
		repeat (300) random_item();
	endtask

	// fill bursts to overflow and drain bursts to underflow, both queues
	task automatic test_queue_limits();
		int unsigned k;
		bit to_peer;
		settle();
		write_reg(CFG_AUTO_DRAIN, flag_word(1'b0));
		write_reg(CFG_STALL_LIMIT, 20'($urandom_range(1, 20'hFFFFF)));
		mix = '{1, 1, 1, 1, 1, 1, 1, 1};
		repeat (12) begin
			to_peer = 1'($urandom_range(0, 1));
			steady = ($urandom_range(0, 3) == 0);
			if (to_peer)
				send_item(ACT_CTRL_WR, 32'h0000_8000 | ($urandom & 32'h0000_4404));
			k = $urandom_range(12, 20);
			repeat (k) begin
				if ($urandom_range(0, 9) == 0) random_item();
				else send_item(to_peer ? ACT_SEND : ACT_PART_PSH, $urandom);
			end
			k = $urandom_range(12, 20);
			repeat (k) begin
				if ($urandom_range(0, 9) == 0) random_item();
				else send_item(to_peer ? ACT_PART_POP : ACT_RECV, $urandom);
			end
		end
		steady = 1'b0;
	endtask

	// mailbox switched off: only receive reads answered, stall counter still runs; then on again
	task automatic test_model_off();
		settle();
		write_reg(CFG_MODEL_ON, flag_word(1'b0));
		write_reg(CFG_STALL_LIMIT, 20'($urandom_range(3, 10)));
		mix = '{3, 2, 1, 2, 2, 2, 2, 1};
		repeat (200) random_item();
		settle();
		write_reg(CFG_MODEL_ON, flag_word(1'b1));
		repeat (50) random_item();
	endtask

	// runs of sync reads around the stall limit, each ended by a sync write
	task automatic test_stall();
		logic [19:0] lim;
		int unsigned k;
		mix = '{0, 0, 2, 2, 2, 2, 2, 2};
		for (int pass = 0; pass < 3; pass++) begin
			settle();
			lim = (pass == 0) ? 20'd1 : (pass == 1) ? 20'($urandom_range(2, 30)) :
			      20'($urandom_range(31, 60));
			write_reg(CFG_STALL_LIMIT, lim);
			repeat (10) begin
				k = $urandom_range(0, lim + 6);
				repeat (k) begin
					if ($urandom_range(0, 4) == 0) random_item();
					else send_item(ACT_SYNC_RD, $urandom);
				end
				send_item(ACT_SYNC_WR, pick_data(ACT_SYNC_WR));
			end
		end
	endtask

	// mostly correct echoes, now and then a wrong one, until the countdown ends
	task automatic test_handshake();
		logic [31:0] d;
		int n;
		settle();
		write_reg(CFG_STALL_LIMIT, 20'd100000);
		mix = '{1, 1, 1, 1, 1, 1, 1, 1};
		n = 0;
		while (!hs_done && n < 400) begin
			if ($urandom_range(0, 2) == 0) send_item(ACT_SYNC_RD, $urandom);
			d = $urandom;
			if ($urandom_range(0, 19) != 0) d[11:8] = peer_nib;
			send_item(ACT_SYNC_WR, d);
			n++;
		end
		// partner is finished: further sync writes change nothing on its side
		repeat (40) random_item();
	endtask

	// random settings per phase, random action mix
	task automatic test_random_all();
		repeat (3) begin
			settle();
			write_reg(CFG_MODEL_ON, flag_word($urandom_range(0, 4) != 0));
			write_reg(CFG_AUTO_DRAIN, flag_word(1'($urandom_range(0, 1))));
			write_reg(CFG_STALL_LIMIT, 20'($urandom_range(1, 200)));
			foreach (mix[i]) mix[i] = $urandom_range(1, 4);
			steady = ($urandom_range(0, 3) == 0);
			repeat (130) random_item();
		end
		steady = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_mixed_traffic();
		test_queue_limits();
		test_model_off();
		test_stall();
		test_handshake();
		test_random_all();
		settle();
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/ipcsf_pkg.sv
rtl/ipcsf_queue.sv
rtl/ipcsf_sync.sv
rtl/interprocessor_sync_fifo_top.sv
rtl/ipcsf_checker.sv
tb/testbench.sv
